// File: hw/rtl/rlse_pkg.sv
// Shared constants, types and codes for the RGB LED strip pulse encoder.
// No dependencies; every other file but rlse_ram imports this package.
package rlse_pkg;

	localparam int unsigned LED_COUNT       = 64;
	localparam int unsigned BRIGHTNESS_FULL = 255;
	localparam int unsigned BITS_PER_PIXEL  = 24;
	localparam int unsigned PIXEL_BITS      = LED_COUNT * BITS_PER_PIXEL;

	localparam int unsigned POS_W      = $clog2(PIXEL_BITS + 256);
	localparam int unsigned LED_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned COLOR_W    = 8;
	localparam int unsigned PIXEL_W    = 3 * COLOR_W;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned BRIGHT_W   = 8;
	localparam int unsigned LATCH_W    = 8;
	localparam int unsigned PROD_W     = COLOR_W + BRIGHT_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BRIGHT_W-1:0] BRIGHT_MIN = 8'd1;
	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'd255;

	localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 8'd255;
	localparam logic [DUTY_W-1:0]   RST_ONE_DUTY   = 16'd60;
	localparam logic [DUTY_W-1:0]   RST_ZERO_DUTY  = 16'd30;
	localparam logic [LATCH_W-1:0]  RST_LATCH      = 8'd50;

	// exact quotient for any product below 2**16 divided by BRIGHTNESS_FULL (255)
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W     = 25;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT) / BRIGHTNESS_FULL + 1);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_CLEAR   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_EMIT    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 2'd3;

	localparam logic [2:0] BIT_MSB   = 3'd7;
	localparam logic [1:0] BYTE_LAST = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CLEAR,
		OP_RESTART,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [LED_W-1:0] led;
		logic [PIXEL_W-1:0] grb;
	} queue_entry_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] brightness;
		logic [DUTY_W-1:0]   one_duty;
		logic [DUTY_W-1:0]   zero_duty;
		logic [LATCH_W-1:0]  latch_slots;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

endpackage

// File: hw/rtl/rlse_if.sv
// Valid/ready channel interfaces: command input, slot output, register writes.
// Depends on rlse_pkg for field widths.
interface rlse_in_if import rlse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [IDX_W-1:0]   pixel_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, cmd, pixel_index, red, green, blue, input ready);
	modport sink (input valid, cmd, pixel_index, red, green, blue, output ready);
endinterface

interface rlse_slot_if import rlse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] slot_duty;
	logic              frame_last;

	modport source (output valid, slot_duty, frame_last, input ready);
	modport sink (input valid, slot_duty, frame_last, output ready);
endinterface

interface rlse_cfg_if import rlse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rlse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlse_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rlse_front.sv
// Front end: accepts commands, decodes them, drops out-of-range pixel writes
// and queues the rest for the back end. Depends on rlse_pkg and rlse_if.
module rlse_front import rlse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rlse_in_if.sink      item,
	input  logic         pop,
	output logic         q_valid,
	output queue_entry_t q_head
);

	queue_entry_t    fifo_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   cnt_q;

	logic         full;
	logic         accept;
	logic         keep;
	logic         push;
	queue_entry_t entry;

	assign full       = (cnt_q == (QA_W + 1)'(QDEPTH));
	assign item.ready = !full;
	assign accept     = item.valid && item.ready;

	always_comb begin
		entry.led = LED_W'(item.pixel_index);
		entry.grb = {item.green, item.red, item.blue};
		keep      = 1'b1;
		case (item.cmd)
			CMD_WRITE: begin
				entry.op = OP_WRITE;
				keep     = ({1'b0, item.pixel_index} < (IDX_W + 1)'(LED_COUNT));
			end
			CMD_CLEAR:   entry.op = OP_CLEAR;
			CMD_RESTART: entry.op = OP_RESTART;
			CMD_EMIT:    entry.op = OP_EMIT;
			default:     entry.op = OP_EMIT;
		endcase
	end

	assign push = accept && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QA_W + 1)'(push) - (QA_W + 1)'(pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_head  = fifo_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QA_W + 1)'(QDEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> (cnt_q == (QA_W + 1)'(QDEPTH)))
		else $error("queue lost an entry while full");

endmodule

// File: hw/rtl/rlse_back.sv
// Back end: runs queued commands against the pixel store and slot position,
// scales the selected byte and drives the slot output register.
// Depends on rlse_pkg, rlse_if and rlse_ram.
module rlse_back import rlse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         q_valid,
	input  queue_entry_t q_head,
	output logic         pop,
	rlse_slot_if.source  slot
);

	back_state_t state_q;
	back_state_t state_nxt;

	logic [POS_W-1:0]     pos_q;
	logic [LED_W-1:0]     led_q;
	logic [1:0]           byte_q;
	logic [2:0]           bitn_q;
	logic [LED_COUNT-1:0] valid_q;

	logic [1:0]          sel_s1;
	logic [2:0]          bitn_s1;
	logic                pix_s1;
	logic                vld_s1;
	logic                last_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic [PROD_W-1:0]   quot_s3;

	logic              out_valid_q;
	logic [DUTY_W-1:0] duty_q;
	logic              last_q;

	logic ram_we;
	logic ram_re;
	logic do_clear;
	logic do_restart;
	logic out_load;
	logic out_free;
	logic [PIXEL_W-1:0] ram_rdata;

	logic [POS_W-1:0] total;
	logic             wrap;
	logic [POS_W-1:0] e_pos;
	logic [LED_W-1:0] e_led;
	logic [1:0]       e_byte;
	logic [2:0]       e_bitn;
	logic             in_pix;
	logic             is_last;

	logic [COLOR_W-1:0]         raw;
	logic [PROD_W+RECIP_W-1:0]  recip_prod;
	logic [COLOR_W-1:0]         val;
	logic [DUTY_W-1:0]          duty;

	assign out_free = !out_valid_q || slot.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_head.op == OP_EMIT) begin
					state_nxt = ST_FETCH;
				end
			end
			ST_FETCH: state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		do_clear   = 1'b0;
		do_restart = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = q_valid;
				if (q_valid) begin
					case (q_head.op)
						OP_WRITE:   ram_we     = 1'b1;
						OP_CLEAR:   do_clear   = 1'b1;
						OP_RESTART: do_restart = 1'b1;
						OP_EMIT:    ram_re     = 1'b1;
						default:    ram_re     = 1'b0;
					endcase
				end
			end
			ST_EMIT:  out_load = out_free;
			default:  out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// slot position and the bit it points at
	assign total   = POS_W'(PIXEL_BITS) + POS_W'(cfg.latch_slots);
	assign wrap    = (pos_q >= total);
	assign e_pos   = wrap ? '0 : pos_q;
	assign e_led   = wrap ? '0 : led_q;
	assign e_byte  = wrap ? '0 : byte_q;
	assign e_bitn  = wrap ? BIT_MSB : bitn_q;
	assign in_pix  = (e_pos < POS_W'(PIXEL_BITS));
	assign is_last = (e_pos == total - POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			led_q  <= '0;
			byte_q <= '0;
			bitn_q <= BIT_MSB;
		end else if (do_restart || (ram_re && is_last)) begin
			pos_q  <= '0;
			led_q  <= '0;
			byte_q <= '0;
			bitn_q <= BIT_MSB;
		end else if (ram_re) begin
			pos_q <= e_pos + POS_W'(1);
			if (e_bitn == '0) begin
				bitn_q <= BIT_MSB;
				if (e_byte == BYTE_LAST) begin
					byte_q <= '0;
					led_q  <= e_led + LED_W'(1);
				end else begin
					byte_q <= e_byte + 2'd1;
					led_q  <= e_led;
				end
			end else begin
				bitn_q <= e_bitn - 3'd1;
				byte_q <= e_byte;
				led_q  <= e_led;
			end
		end
	end

	// entries never written since reset or a clear read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_clear) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[q_head.led] <= 1'b1;
		end
	end

	rlse_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (LED_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_head.led),
		.wdata (q_head.grb),
		.re    (ram_re),
		.raddr (e_led),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ram_re) begin
			sel_s1  <= e_byte;
			bitn_s1 <= e_bitn;
			pix_s1  <= in_pix;
			vld_s1  <= in_pix && valid_q[e_led];
			last_s1 <= is_last;
		end
	end

	always_comb begin
		case (sel_s1)
			2'd0:    raw = ram_rdata[2*COLOR_W +: COLOR_W];
			2'd1:    raw = ram_rdata[COLOR_W +: COLOR_W];
			2'd2:    raw = ram_rdata[0 +: COLOR_W];
			default: raw = '0;
		endcase
		if (!vld_s1) begin
			raw = '0;
		end
	end

	assign recip_prod = (PROD_W + RECIP_W)'(prod_s2) * (PROD_W + RECIP_W)'(RECIP);

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			prod_s2 <= PROD_W'(raw) * PROD_W'(cfg.brightness);
		end
		if (state_q == ST_SCALE) begin
			quot_s3 <= recip_prod[RECIP_SHIFT +: PROD_W];
		end
	end

	assign val  = (quot_s3 > PROD_W'(255)) ? 8'hFF : quot_s3[COLOR_W-1:0];
	assign duty = !pix_s1 ? '0 : (val[bitn_s1] ? cfg.one_duty : cfg.zero_duty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (slot.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty_q <= duty;
			last_q <= last_s1;
		end
	end

	assign slot.valid      = out_valid_q;
	assign slot.slot_duty  = duty_q;
	assign slot.frame_last = last_q;

	a_fetch_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_SCALE))
		else $error("scale stage skipped");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q != 2'd3)
		else $error("byte counter out of range");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue popped while busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !slot.ready) |-> !out_load)
		else $error("output register overwritten");

endmodule

// File: hw/rtl/rgb_led_strip_pulse_encoder.sv
// Top level of the RGB LED strip pulse encoder: register file, front end and back end.
// Depends on rlse_pkg, rlse_if, rlse_front and rlse_back.
//
//   channel  dir  payload                                   transaction
//   item     in   cmd, pixel_index, red, green, blue        item.valid & item.ready
//   slot     out  slot_duty, frame_last                     slot.valid & slot.ready
//   cfg      in   index, data                               cfg.valid & cfg.ready
//
// Write, clear and restart are done in the idle state; an emit goes through store read,
// brightness multiply, reciprocal multiply and output load, and no further command is
// taken until it is through. A two-entry queue decouples intake from work.
// Reset clears the store at once through per-pixel valid bits; no clearing pass.
// A slot held in the output register stalls only an emit's load; cfg.ready is always high.
module rgb_led_strip_pulse_encoder import rlse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rlse_in_if.sink     item,
	rlse_slot_if.source slot,
	rlse_cfg_if.sink    cfg
);

	cfg_t         cfg_q;
	logic         cfg_we;
	logic         q_valid;
	logic         pop;
	queue_entry_t q_head;
	logic [BRIGHT_W-1:0] bright_in;
	logic [BRIGHT_W-1:0] bright_clamped;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	assign bright_in      = cfg.data[BRIGHT_W-1:0];
	assign bright_clamped = (bright_in < BRIGHT_MIN) ? BRIGHT_MIN :
	                        (bright_in > BRIGHT_MAX) ? BRIGHT_MAX : bright_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness  <= RST_BRIGHTNESS;
			cfg_q.one_duty    <= RST_ONE_DUTY;
			cfg_q.zero_duty   <= RST_ZERO_DUTY;
			cfg_q.latch_slots <= RST_LATCH;
		end else if (cfg_we) begin
			case (cfg.index)
				REG_BRIGHTNESS: cfg_q.brightness  <= bright_clamped;
				REG_ONE_DUTY:   cfg_q.one_duty    <= cfg.data[DUTY_W-1:0];
				REG_ZERO_DUTY:  cfg_q.zero_duty   <= cfg.data[DUTY_W-1:0];
				REG_LATCH:      cfg_q.latch_slots <= cfg.data[LATCH_W-1:0];
				default:        cfg_q             <= cfg_q;
			endcase
		end
	end

	rlse_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.pop     (pop),
		.q_valid (q_valid),
		.q_head  (q_head)
	);

	rlse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.slot    (slot)
	);

	a_bright_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.brightness >= BRIGHT_MIN)
		else $error("brightness below minimum");

	a_bright_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg.index == REG_BRIGHTNESS) |=> (cfg_q.brightness == $past(bright_clamped)))
		else $error("brightness write not taken");

	a_duty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(cfg_q))
		else $error("register changed without a write");

endmodule
